FILE: hw/rtl/tdpt_pkg.sv
package tdpt_pkg;

   localparam int VALUE_BITS = 32;
   localparam int CANDIDATE_BITS = 32;
   localparam int CNT_BITS = (VALUE_BITS > 2) ? $clog2(VALUE_BITS) : 1;

   localparam logic [VALUE_BITS-1:0] VALUE_TWO = VALUE_BITS'(2);
   localparam logic [VALUE_BITS-1:0] VALUE_THREE = VALUE_BITS'(3);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(VALUE_BITS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_CHECK,
      ST_FINISH
   } state_type;

endpackage

FILE: hw/rtl/trial_division_prime_test.sv
// Values below 3 and even values finish without any division; for other
// values the divider runs once per odd trial divisor, starting at three.
// One item is taken at a time; the worst case for 32-bit values is about
// 32768 divisors, and the time per divisor is set by the bit-serial
// restoring divider that produces one quotient bit a cycle.
// Reset: synchronous, active high; clears the sequencer and the result valid.
module trial_division_prime_test (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [tdpt_pkg::CANDIDATE_BITS-1:0]   req_candidate,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_prime_flag
);

   localparam int W = tdpt_pkg::VALUE_BITS;

   tdpt_pkg::state_type state_ff, state_in;

   logic [W-1:0] value_ff, value_in;
   logic [W-1:0] div_ff, div_in;
   logic [W-1:0] rem_ff, rem_in;
   logic [W-1:0] quo_ff, quo_in;
   logic [tdpt_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   logic flag_ff, flag_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_flag_ff, rsp_flag_in;

   logic req_accept;
   logic out_load;
   logic [W-1:0] req_value;
   logic [W:0] shifted;
   logic [W:0] diff;
   logic quo_bit;
   logic trivial;

   assign req_value = W'(req_candidate);
   assign req_accept = req_valid && !req_stall;
   assign trivial = (req_value < tdpt_pkg::VALUE_TWO) || !req_value[0];

   assign shifted = {rem_ff, quo_ff[W-1]};
   assign diff = shifted - {1'b0, div_ff};
   assign quo_bit = !diff[W];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tdpt_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = trivial ? tdpt_pkg::ST_FINISH : tdpt_pkg::ST_DIVIDE;
            end
         end
         tdpt_pkg::ST_DIVIDE: begin
            if (cnt_ff == '0) begin
               state_in = tdpt_pkg::ST_CHECK;
            end
         end
         tdpt_pkg::ST_CHECK: begin
            if ((div_ff > quo_ff) || (rem_ff == '0)) begin
               state_in = tdpt_pkg::ST_FINISH;
            end else begin
               state_in = tdpt_pkg::ST_DIVIDE;
            end
         end
         tdpt_pkg::ST_FINISH: begin
            if (out_load) begin
               state_in = tdpt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tdpt_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      out_load = 1'b0;
      case (state_ff)
         tdpt_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         tdpt_pkg::ST_FINISH: begin
            out_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      value_in = value_ff;
      div_in = div_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      flag_in = flag_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_flag_in = rsp_flag_ff;
      case (state_ff)
         tdpt_pkg::ST_IDLE: begin
            if (req_accept) begin
               value_in = req_value;
               flag_in = (req_value == tdpt_pkg::VALUE_TWO);
               div_in = tdpt_pkg::VALUE_THREE;
               rem_in = '0;
               quo_in = req_value;
               cnt_in = tdpt_pkg::CNT_LAST;
            end
         end
         tdpt_pkg::ST_DIVIDE: begin
            rem_in = quo_bit ? diff[W-1:0] : shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], quo_bit};
            cnt_in = cnt_ff - 1'b1;
         end
         tdpt_pkg::ST_CHECK: begin
            if (div_ff > quo_ff) begin
               flag_in = 1'b1;
            end else if (rem_ff == '0) begin
               flag_in = 1'b0;
            end else begin
               div_in = div_ff + tdpt_pkg::VALUE_TWO;
               rem_in = '0;
               quo_in = value_ff;
               cnt_in = tdpt_pkg::CNT_LAST;
            end
         end
         tdpt_pkg::ST_FINISH: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_flag_in = flag_ff;
            end
         end
         default: begin
            flag_in = flag_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tdpt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      flag_ff <= flag_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_prime_flag = rsp_flag_ff;

   // The trial divisor is always odd and at least three while dividing.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == tdpt_pkg::ST_DIVIDE) |-> (div_ff[0] && (div_ff >= tdpt_pkg::VALUE_THREE)))
      else $error("trial divisor is even or below three");

   // A finished division leaves a remainder below the divisor.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == tdpt_pkg::ST_CHECK) |-> (rem_ff < div_ff))
      else $error("remainder not below divisor");

   // Once an item is accepted, no further item is taken until it finishes.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("second item accepted while busy");

   // Only a loaded result raises the output valid.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && !out_load) |=> !rsp_valid_ff)
      else $error("result valid without a finished item");

endmodule
